// ===== rtl/rmst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants of the range-minimum segment tree
// Word layouts of both channels, the command word passed from the front
// end to the tree walker, status codes and the back-end state type.
// ----------------------------------------------------------------------------
package rmst_pkg;

	localparam int VAL_W = 32;
	localparam int IDX_W = 10;
	localparam int LC_W  = 11;

	// Value of an empty node and of an empty range
	localparam logic signed [VAL_W-1:0] TOP_VALUE = 32'sh7FFF_FFFF;

	localparam logic [LC_W-1:0] LEAF_COUNT_RESET = 11'd1024;

	// Request types
	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_UPDATE = 2'd0;
	localparam logic [1:0] ST_QUERY  = 2'd1;
	localparam logic [1:0] ST_ERROR  = 2'd2;

	typedef struct packed {
		logic                    req_type;
		logic [IDX_W-1:0]        first_index;
		logic [IDX_W-1:0]        last_index;
		logic signed [VAL_W-1:0] new_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] range_minimum;
		logic [1:0]              status;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_UPDATE,
		CMD_QUERY,
		CMD_EMPTY,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [IDX_W-1:0]        first_index;
		logic [IDX_W-1:0]        last_index;
		logic signed [VAL_W-1:0] new_value;
	} cmd_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_UPD,
		B_QRY,
		B_DONE
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/rmst_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_front: request intake and classification
// Holds the effective leaf count, checks request indices against it and
// queues classified commands for the tree walker.
// ----------------------------------------------------------------------------
module rmst_front import rmst_pkg::*; #(
	parameter  int MAX_LEAVES = 1024,
	localparam int NODE_W     = $clog2(2 * MAX_LEAVES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req_data,
	input  wire logic              cfg_we,
	input  wire logic [LC_W-1:0]   cfg_wdata,
	input  wire logic              clearing,
	output logic                   cmd_valid,
	output cmd_t                   cmd,
	input  wire logic              cmd_pop,
	output logic [NODE_W-1:0]      leaves
);

	localparam int CW = (NODE_W > LC_W) ? NODE_W : LC_W;
	localparam int QD = 2;
	localparam int QA = $clog2(QD);
	localparam int QC = $clog2(QD + 1);

	// Zero acts as one leaf, anything above the tree size as a full tree
	function automatic logic [NODE_W-1:0] clamp_leaves(input logic [LC_W-1:0] v);
		logic [NODE_W-1:0] r;
		if (v == '0) begin
			r = NODE_W'(1);
		end else if (CW'(v) > CW'(MAX_LEAVES)) begin
			r = NODE_W'(MAX_LEAVES);
		end else begin
			r = NODE_W'(v);
		end
		return r;
	endfunction

	localparam logic [NODE_W-1:0] LEAVES_RESET = clamp_leaves(LEAF_COUNT_RESET);

	logic [NODE_W-1:0] leaves_q;
	cmd_t              q_mem [QD];
	logic [QA-1:0]     wr_ptr_q;
	logic [QA-1:0]     rd_ptr_q;
	logic [QC-1:0]     cnt_q;
	cmd_t              new_cmd;
	logic              first_bad;
	logic              last_bad;
	logic              push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaves_q <= LEAVES_RESET;
		end else if (cfg_we) begin
			leaves_q <= clamp_leaves(cfg_wdata);
		end
	end

	assign leaves = leaves_q;

	// Classify
	always_comb begin
		first_bad           = CW'(req_data.first_index) >= CW'(leaves_q);
		last_bad            = CW'(req_data.last_index) >= CW'(leaves_q);
		new_cmd.first_index = req_data.first_index;
		new_cmd.last_index  = req_data.last_index;
		new_cmd.new_value   = req_data.new_value;
		unique case (req_data.req_type)
			REQ_UPDATE: begin
				new_cmd.kind = first_bad ? CMD_ERROR : CMD_UPDATE;
			end
			REQ_QUERY: begin
				if (first_bad || last_bad) begin
					new_cmd.kind = CMD_ERROR;
				end else if (req_data.first_index > req_data.last_index) begin
					new_cmd.kind = CMD_EMPTY;
				end else begin
					new_cmd.kind = CMD_QUERY;
				end
			end
		endcase
	end

	assign req_ready = !clearing && !cfg_we && (cnt_q != QC'(QD));
	assign push      = req_valid && req_ready;
	assign cmd_valid = cnt_q != '0;
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QA'(QD - 1)) ? '0 : wr_ptr_q + QA'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == QA'(QD - 1)) ? '0 : rd_ptr_q + QA'(1);
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + QC'(1);
			end else if (cmd_pop && !push) begin
				cnt_q <= cnt_q - QC'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rmst_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_back: tree walker
// Owns the node memory; runs the clearing pass, point updates (one level
// a cycle) and range queries (one level a cycle), and holds the result.
// ----------------------------------------------------------------------------
module rmst_back import rmst_pkg::*; #(
	parameter  int MAX_LEAVES = 1024,
	localparam int NODE_W     = $clog2(2 * MAX_LEAVES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [NODE_W-1:0] leaves,
	input  wire logic              cmd_valid,
	input  wire cmd_t              cmd,
	output logic                   cmd_pop,
	output logic                   clearing,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp_data
);

	localparam int NODE_COUNT = 2 * MAX_LEAVES;
	localparam int CW         = (NODE_W > IDX_W) ? NODE_W : IDX_W;
	localparam int SW         = CW + 1;

	function automatic logic signed [VAL_W-1:0] min_s(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b);
		return (a <= b) ? a : b;
	endfunction

	logic signed [VAL_W-1:0] node_mem [NODE_COUNT];
	logic signed [VAL_W-1:0] rd_a_q, rd_b_q;

	back_state_t             state_q, state_d;
	logic [NODE_W-1:0]       clr_q, clr_d;
	logic [NODE_W-1:0]       lo_q, lo_d, hi_q, hi_d;
	logic signed [VAL_W-1:0] left_q, left_d, right_q, right_d;
	rsp_t                    res_q, res_d;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;
	logic                    load_out;

	logic                    mem_we;
	logic [NODE_W-1:0]       mem_waddr, ra, rb;
	logic signed [VAL_W-1:0] mem_wdata;

	logic                    lo_odd, hi_even;
	logic signed [VAL_W-1:0] left_nx, right_nx, upd_min;
	logic [NODE_W-1:0]       lo_nx, hi_nx, parent, lo_leaf, hi_leaf;
	logic [NODE_W:0]         lo_inc;

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		left_d    = left_q;
		right_d   = right_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = lo_q;
		mem_wdata = TOP_VALUE;
		ra        = lo_q;
		rb        = hi_q;
		cmd_pop   = 1'b0;
		load_out  = 1'b0;

		lo_odd    = lo_q[0];
		hi_even   = !hi_q[0];
		left_nx   = lo_odd ? min_s(left_q, rd_a_q) : left_q;
		right_nx  = hi_even ? min_s(rd_b_q, right_q) : right_q;
		lo_inc    = {1'b0, lo_q} + (NODE_W + 1)'(lo_odd);
		lo_nx     = lo_inc[NODE_W:1];
		hi_nx     = (hi_q - NODE_W'(hi_even)) >> 1;
		upd_min   = min_s(left_q, rd_a_q);
		parent    = lo_q >> 1;
		lo_leaf   = NODE_W'(SW'(cmd.first_index) + SW'(leaves));
		hi_leaf   = NODE_W'(SW'(cmd.last_index) + SW'(leaves));

		unique case (state_q)
			B_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = TOP_VALUE;
				if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
					state_d = B_IDLE;
				end else begin
					clr_d = clr_q + NODE_W'(1);
				end
			end
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						CMD_UPDATE: begin
							// write the leaf, fetch its sibling
							mem_we    = 1'b1;
							mem_waddr = lo_leaf;
							mem_wdata = cmd.new_value;
							ra        = lo_leaf ^ NODE_W'(1);
							lo_d      = lo_leaf;
							left_d    = cmd.new_value;
							res_d     = '{range_minimum: '0, status: ST_UPDATE};
							state_d   = (lo_leaf == NODE_W'(1)) ? B_DONE : B_UPD;
						end
						CMD_QUERY: begin
							ra      = lo_leaf;
							rb      = hi_leaf;
							lo_d    = lo_leaf;
							hi_d    = hi_leaf;
							left_d  = TOP_VALUE;
							right_d = TOP_VALUE;
							state_d = B_QRY;
						end
						CMD_EMPTY: begin
							res_d   = '{range_minimum: TOP_VALUE, status: ST_QUERY};
							state_d = B_DONE;
						end
						CMD_ERROR: begin
							res_d   = '{range_minimum: '0, status: ST_ERROR};
							state_d = B_DONE;
						end
					endcase
				end
			end
			B_UPD: begin
				// parent takes the smaller of the path value and the sibling
				mem_we    = 1'b1;
				mem_waddr = parent;
				mem_wdata = upd_min;
				left_d    = upd_min;
				lo_d      = parent;
				ra        = parent ^ NODE_W'(1);
				if (parent == NODE_W'(1)) begin
					state_d = B_DONE;
				end
			end
			B_QRY: begin
				left_d  = left_nx;
				right_d = right_nx;
				lo_d    = lo_nx;
				hi_d    = hi_nx;
				ra      = lo_nx;
				rb      = hi_nx;
				if (lo_nx > hi_nx) begin
					res_d   = '{range_minimum: min_s(left_nx, right_nx), status: ST_QUERY};
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_CLEAR;
				clr_d   = '0;
			end
		endcase

		// a new leaf count invalidates every node
		if (cfg_we) begin
			state_d = B_CLEAR;
			clr_d   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= node_mem[ra];
		rd_b_q <= node_mem[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		left_q  <= left_d;
		right_q <= right_d;
		res_q   <= res_d;
		if (load_out) begin
			rsp_q <= res_q;
		end
	end

	assign clearing  = state_q == B_CLEAR;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/range_min_segment_tree.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// range_min_segment_tree: bottom-up segment tree with range-minimum query
// Point updates rewrite a leaf and its ancestors; queries climb from both
// ends of an inclusive range. Empty nodes and empty ranges read as the
// largest signed 32-bit value.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             word
//   req       in         req_valid/req_ready   req_t  (type, indices, value)
//   rsp       out        rsp_valid/rsp_ready   rsp_t  (minimum, status)
//   cfg       in         cfg_we (no wait)      leaf_count, 11 bits
//
// Walk: one word is walked at a time, one tree level per cycle through a
//   node memory with one write and two read ports. An update climbs from
//   the leaf to the root, a query until its two ends cross; errors and
//   empty ranges skip the walk and go straight to the result hold.
// Reset: the node memory is swept to the empty value, one node a cycle,
//   after reset and after every leaf_count write; no request word is
//   taken during the sweep.
// Stalls: a two-entry queue sits between intake and the walker, and a held
//   result does not stop the next word being walked.
//
module range_min_segment_tree import rmst_pkg::*; #(
	parameter int MAX_LEAVES = 1024
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire req_t            req_data,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output rsp_t                 rsp_data,
	input  wire logic            cfg_we,
	input  wire logic [LC_W-1:0] cfg_wdata
);

	localparam int NODE_W = $clog2(2 * MAX_LEAVES);

	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_pop;
	logic              clearing;
	logic [NODE_W-1:0] leaves;

	// Intake: hold leaf count, range-check indices, queue the word
	rmst_front #(
		.MAX_LEAVES (MAX_LEAVES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.clearing  (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.leaves    (leaves)
	);

	// Walker: node memory, clearing sweep, level-per-cycle climb, result hold
	rmst_back #(
		.MAX_LEAVES (MAX_LEAVES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.leaves    (leaves),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule
`default_nettype wire
